// ===== hdl/gwm_pkg.sv =====
// Shared types, constants and helpers for the glob wildcard matcher.
// Used by gwm_cell and by the top level glob_wildcard_matcher; no dependencies.
package gwm_pkg;

  // Pattern geometry.
  localparam int PATTERN_MAX = 32;
  localparam int POS_LIMIT   = (PATTERN_MAX < 32) ? PATTERN_MAX : 32;
  localparam int NUM_POS     = POS_LIMIT + 1;
  localparam int CNT_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int NUM_WORDS   = 4;
  localparam int WORD_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int REG_IDX_W   = 3;

  // Pattern metacharacters.
  localparam logic [BYTE_W-1:0] CHAR_STAR     = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_QUESTION = 8'h3F;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_PAT0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT2  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT3  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FOLD  = 3'd5;

  // Signals that one cell hands to the next position.
  typedef struct packed {
    logic sa;  // literal match moves into the next position
    logic sj;  // '?' begins a character, next position mid-character
    logic ca;  // star closure of the boundary set
    logic cj;  // star closure of the mid-character set
    logic cs;  // star closure of the start set
  } gwm_link_t;

  // Controls broadcast from the top level to every cell.
  typedef struct packed {
    logic              load;
    logic              fresh;
    logic              cont;
    logic              fold_case;
    logic [CNT_W-1:0]  len;
    logic [BYTE_W-1:0] text_f;
  } gwm_ctl_t;

  // ASCII case folding of a literal byte.
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic en);
    logic [BYTE_W-1:0] r;
    r = b;
    if (en && (b inside {[8'h41:8'h5A]})) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== hdl/gwm_cell.sv =====
// One pattern position of the matcher: its state bits and its transitions.
// Depends on gwm_pkg for the link and control structs and the fold helper.
module gwm_cell (
  input  logic                        clk,
  input  logic [gwm_pkg::CNT_W-1:0]   idx,
  input  logic [gwm_pkg::BYTE_W-1:0]  pat_byte,
  input  gwm_pkg::gwm_ctl_t           ctl,
  input  gwm_pkg::gwm_link_t          lk_in,
  output gwm_pkg::gwm_link_t          lk_out,
  output logic                        hit
);
  import gwm_pkg::*;

  logic a_r, a_nxt;
  logic j_r, j_nxt;
  logic st_r, st_nxt;
  logic en, is_fin, is_star, is_q, lit;
  logic cur_a, cur_j, from;

  // Position decode against the active pattern length.
  assign en      = (idx < ctl.len);
  assign is_fin  = (idx == ctl.len);
  assign is_star = (pat_byte == CHAR_STAR);
  assign is_q    = (pat_byte == CHAR_QUESTION);
  assign lit     = (fold_byte(pat_byte, ctl.fold_case) == ctl.text_f);

  // A fresh string starts from the registered start closure.
  assign cur_a = ctl.fresh ? st_r : a_r;
  assign cur_j = ctl.fresh ? 1'b0 : j_r;
  assign from  = ctl.cont ? cur_a : (cur_a | cur_j);

  // Next bits of this position, closed over stars of the previous one.
  assign a_nxt = lk_in.sa | lk_in.ca;
  assign j_nxt = (ctl.cont & cur_j) | (from & is_star & en) | lk_in.sj | lk_in.cj;

  // Start closure is recomputed every cycle from the configuration.
  assign st_nxt = (idx == '0) | lk_in.cs;

  // Hand transitions and closures on to the next position.
  always_comb begin
    lk_out.sa = from & en & ~is_star & ~is_q & lit;
    lk_out.sj = from & en & is_q;
    lk_out.ca = a_nxt & is_star & en;
    lk_out.cj = j_nxt & is_star & en;
    lk_out.cs = st_nxt & is_star & en;
  end

  // The final position reports the match bit after this request.
  assign hit = is_fin & (ctl.load ? (a_nxt | j_nxt) : (cur_a | cur_j));

  // The a and j bits update only when a byte arrives; st_r updates every cycle.
  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (ctl.load) begin
      a_r <= a_nxt;
      j_r <= j_nxt;
    end
  end

endmodule

// ===== hdl/glob_wildcard_matcher.sv =====
// Top level of the glob wildcard matcher: configuration registers, the row of
// position cells and the result register. Depends on gwm_pkg and gwm_cell.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_text_byte,       | request in
//           | in_has_byte, in_is_last                 |
//   out     | out_valid, out_stall, out_matched       | result out
//   cfg     | psel, penable, pwrite, paddr, pwdata,   | APB write/read
//           | prdata, pready                          |
//
// One request is taken every cycle while in_stall is low; the match bit of the
// last request of a string is registered and appears on out in the cycle after it is taken.
// The per-byte update ripples combinationally through the row of position cells.
// Reset is synchronous, active low; the input stalls in the cycle after reset
// and after every register write while the start closure is rebuilt.
// While a result waits under out_stall, the input stalls as well; a new
// request is taken again in the cycle in which the waiting result leaves.
module glob_wildcard_matcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gwm_pkg::BYTE_W-1:0]    in_text_byte,
  input  logic                          in_has_byte,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_matched,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gwm_pkg::ADDR_W-1:0]    paddr,
  input  logic [gwm_pkg::WORD_W-1:0]    pwdata,
  output logic [gwm_pkg::WORD_W-1:0]    prdata,
  output logic                          pready
);
  import gwm_pkg::*;

  logic [WORD_W-1:0]            pat_r [NUM_WORDS];
  logic [CNT_W-1:0]             cnt_r;
  logic                         fold_r;
  logic                         fresh_r, fresh_nxt;
  logic                         settle_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_matched_r;
  logic [REG_IDX_W-1:0]         reg_idx;
  logic                         wr_en, cfg_hit;
  logic                         in_acc;
  logic [CNT_W-1:0]             len;
  logic [NUM_WORDS*WORD_W-1:0]  pat_flat;
  gwm_ctl_t                     ctl;
  gwm_link_t                    link [NUM_POS+1];
  logic [NUM_POS-1:0]           hit_vec;

  // Configuration port decode.
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg_hit = wr_en & (reg_idx <= REG_FOLD);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        pat_r[i] <= '0;
      end
      cnt_r  <= '0;
      fold_r <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAT0:  pat_r[0] <= pwdata;
        REG_PAT1:  pat_r[1] <= pwdata;
        REG_PAT2:  pat_r[2] <= pwdata;
        REG_PAT3:  pat_r[3] <= pwdata;
        REG_COUNT: cnt_r    <= pwdata[CNT_W-1:0];
        REG_FOLD:  fold_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_PAT0:  prdata = pat_r[0];
      REG_PAT1:  prdata = pat_r[1];
      REG_PAT2:  prdata = pat_r[2];
      REG_PAT3:  prdata = pat_r[3];
      REG_COUNT: prdata = {{(WORD_W-CNT_W){1'b0}}, cnt_r};
      REG_FOLD:  prdata = {{(WORD_W-1){1'b0}}, fold_r};
      default:   prdata = '0;
    endcase
  end

  // Effective pattern length, clipped to the number of pattern positions.
  assign len = (cnt_r > CNT_W'(POS_LIMIT)) ? CNT_W'(POS_LIMIT) : cnt_r;

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      pat_flat[i*WORD_W +: WORD_W] = pat_r[i];
    end
  end

  // Input handshake: hold off while restarting or while a result is blocked.
  assign in_stall = settle_r | (out_valid_r & out_stall);
  assign in_acc   = in_valid & ~in_stall;

  // Broadcast controls for the cell row.
  always_comb begin
    ctl.load      = in_acc & in_has_byte;
    ctl.fresh     = fresh_r;
    ctl.cont      = (in_text_byte[7:6] == 2'b10);
    ctl.fold_case = fold_r;
    ctl.len       = len;
    ctl.text_f    = fold_byte(in_text_byte, fold_r);
  end

  // Row of position cells, one per pattern position plus the end position.
  assign link[0] = '0;

  for (genvar p = 0; p < NUM_POS; p++) begin : g_cell
    logic [BYTE_W-1:0] pbyte;
    if (p < POS_LIMIT) begin : g_byte
      assign pbyte = pat_flat[p*BYTE_W +: BYTE_W];
    end else begin : g_end
      assign pbyte = '0;
    end

    gwm_cell u_cell (
      .clk      (clk),
      .idx      (CNT_W'(p)),
      .pat_byte (pbyte),
      .ctl      (ctl),
      .lk_in    (link[p]),
      .lk_out   (link[p+1]),
      .hit      (hit_vec[p])
    );
  end

  // String state: a restart marks the next string as fresh.
  always_comb begin
    fresh_nxt = fresh_r;
    if (cfg_hit) begin
      fresh_nxt = 1'b1;
    end else if (in_acc) begin
      if (in_is_last) begin
        fresh_nxt = 1'b1;
      end else if (in_has_byte) begin
        fresh_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r  <= 1'b1;
      settle_r <= 1'b1;
    end else begin
      fresh_r  <= fresh_nxt;
      settle_r <= cfg_hit;
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_acc && in_is_last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_is_last) begin
      out_matched_r <= |hit_vec;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

`ifndef SYNTH
  // A register write holds off the input for the following cycle.
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> in_stall)
    else $error("input not held off after a register write");

  // The last request of a string always yields a result and marks the next string fresh.
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_is_last) |=> (out_valid && fresh_r))
    else $error("last request gave no result or no restart");

  // Other requests never create a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_is_last && !(out_valid && out_stall)) |=> !out_valid)
    else $error("result without a last request");
`endif

endmodule
